// ===== hw/rtl/sha1_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha1_pkg
// Shared types, constants and round functions of the SHA-1 byte hasher.
// ----------------------------------------------------------------------------
package sha1_pkg;

  localparam logic [31:0] H0 = 32'h67452301;
  localparam logic [31:0] H1 = 32'hEFCDAB89;
  localparam logic [31:0] H2 = 32'h98BADCFE;
  localparam logic [31:0] H3 = 32'h10325476;
  localparam logic [31:0] H4 = 32'hC3D2E1F0;

  localparam logic [31:0] K0 = 32'h5A827999;
  localparam logic [31:0] K1 = 32'h6ED9EBA1;
  localparam logic [31:0] K2 = 32'h8F1BBCDC;
  localparam logic [31:0] K3 = 32'hCA62C1D6;

  localparam logic [7:0] PadMarker = 8'h80;
  localparam int unsigned RndW     = 7;
  localparam logic [RndW-1:0] LastRnd = 7'd79;

  typedef logic [4:0][31:0] chain_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_COMP,
    S_FOLD,
    S_PAD,
    S_DONE
  } state_e;

  typedef struct packed {
    logic rnd_en;
    logic fold;
    logic reinit;
  } core_ctl_t;

  function automatic logic [31:0] round_f(input logic [RndW-1:0] rnd,
                                          input logic [31:0] b,
                                          input logic [31:0] c,
                                          input logic [31:0] d);
    logic [31:0] res;
    if (rnd < 7'd20) begin
      res = (b & c) | (~b & d);
    end else if (rnd < 7'd40) begin
      res = b ^ c ^ d;
    end else if (rnd < 7'd60) begin
      res = (b & c) | (b & d) | (c & d);
    end else begin
      res = b ^ c ^ d;
    end
    return res;
  endfunction

  function automatic logic [31:0] round_k(input logic [RndW-1:0] rnd);
    logic [31:0] res;
    if (rnd < 7'd20) begin
      res = K0;
    end else if (rnd < 7'd40) begin
      res = K1;
    end else if (rnd < 7'd60) begin
      res = K2;
    end else begin
      res = K3;
    end
    return res;
  endfunction

endpackage

// ===== hw/rtl/sha1_sched.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha1_sched
// Block buffer and message schedule: 16-word window, byte writes while
// filling, one expanded word per round while compressing.
// ----------------------------------------------------------------------------
module sha1_sched (
  input  logic        clk_i,
  input  logic        wr_en_i,
  input  logic [5:0]  wr_idx_i,
  input  logic [7:0]  wr_byte_i,
  input  logic        shift_en_i,
  input  logic        rnd_lt16_i,
  output logic [31:0] w_o
);

  logic [15:0][31:0] w_q;
  logic [31:0]       mix;
  logic [31:0]       w_new;
  logic [4:0]        lane_lsb;

  assign mix      = w_q[13] ^ w_q[8] ^ w_q[2] ^ w_q[0];
  assign w_new    = rnd_lt16_i ? w_q[0] : {mix[30:0], mix[31]};
  assign w_o      = w_new;
  // byte 0 of a word is its most significant byte
  assign lane_lsb = {~wr_idx_i[1:0], 3'b000};

  always_ff @(posedge clk_i) begin
    if (shift_en_i) begin
      for (int i = 0; i < 15; i++) begin
        w_q[i] <= w_q[i+1];
      end
      w_q[15] <= w_new;
    end else if (wr_en_i) begin
      w_q[wr_idx_i[5:2]][lane_lsb +: 8] <= wr_byte_i;
    end
  end

endmodule

// ===== hw/rtl/sha1_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha1_core
// Chaining words and working variables; one compression round per cycle.
// ----------------------------------------------------------------------------
module sha1_core (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  sha1_pkg::core_ctl_t         ctl_i,
  input  logic [sha1_pkg::RndW-1:0]   rnd_i,
  input  logic [31:0]                 w_i,
  output sha1_pkg::chain_t            chain_o
);

  sha1_pkg::chain_t chain_q, chain_d;
  sha1_pkg::chain_t work_q, work_d;
  sha1_pkg::chain_t init_val;
  sha1_pkg::chain_t sum;
  logic [31:0]      t;

  // work_q[0..4] = a..e
  assign init_val = {sha1_pkg::H4, sha1_pkg::H3, sha1_pkg::H2, sha1_pkg::H1, sha1_pkg::H0};

  assign t = {work_q[0][26:0], work_q[0][31:27]}
           + sha1_pkg::round_f(rnd_i, work_q[1], work_q[2], work_q[3])
           + work_q[4] + sha1_pkg::round_k(rnd_i) + w_i;

  always_comb begin
    for (int i = 0; i < 5; i++) begin
      sum[i] = chain_q[i] + work_q[i];
    end
  end

  always_comb begin
    chain_d = chain_q;
    work_d  = work_q;
    if (ctl_i.reinit) begin
      chain_d = init_val;
      work_d  = init_val;
    end else if (ctl_i.fold) begin
      chain_d = sum;
      work_d  = sum;
    end else if (ctl_i.rnd_en) begin
      work_d[0] = t;
      work_d[1] = work_q[0];
      work_d[2] = {work_q[1][1:0], work_q[1][31:2]};
      work_d[3] = work_q[2];
      work_d[4] = work_q[3];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chain_q <= init_val;
      work_q  <= init_val;
    end else begin
      chain_q <= chain_d;
      work_q  <= work_d;
    end
  end

  assign chain_o = chain_q;

endmodule

// ===== hw/rtl/sha1_byte_stream_hasher.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha1_byte_stream_hasher
// SHA-1 over a byte stream: one byte per item, digest on the final byte.
// ----------------------------------------------------------------------------
// channel   dir  payload                              handshake
// s_axis    in   tdata[7:0] data_byte, tlast last      tvalid/tready
// m_axis    out  tdata[159:0] digest_word0..4         tvalid/tready
//
// Every 64th byte starts a compression on the shared round unit: 80 rounds
// into the working variables, then a fold into the chaining words.
// On the final byte padding is written one byte per cycle up to the block
// end, then one or two compressions run; the digest loads into the output
// register once that register is free.
// s_axis_tready is low during compression, padding and digest hand-off.
// Reset is asynchronous and restores the initial chaining words.
// ----------------------------------------------------------------------------
module sha1_byte_stream_hasher (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [7:0]   s_axis_tdata,   // [7:0] data_byte
  input  logic         s_axis_tlast,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [159:0] m_axis_tdata    // digest_word0, word1, word2, word3, word4
);

  sha1_pkg::state_e            state_q, state_d;
  logic [5:0]                  fill_q;
  logic [sha1_pkg::RndW-1:0]   rnd_q;
  logic [63:0]                 bitlen_q;
  logic                        pad_q, marker_q, ext_q, lenblk_q;
  logic                        out_valid_q;
  logic [159:0]                out_data_q;

  logic                        s_acc;
  logic                        out_free;
  logic                        wr_en;
  logic [7:0]                  wr_byte;
  logic [7:0]                  pad_byte;
  logic                        ext_next;
  logic [31:0]                 w;
  sha1_pkg::core_ctl_t         ctl;
  sha1_pkg::chain_t            chain;

  assign s_acc    = s_axis_tvalid & s_axis_tready;
  assign out_free = !out_valid_q || m_axis_tready;
  assign ext_next = ext_q | (marker_q & (fill_q[5:3] == 3'b111));
  assign pad_byte = marker_q ? sha1_pkg::PadMarker :
                    ((fill_q[5:3] == 3'b111) && !ext_q) ?
                    bitlen_q[{~fill_q[2:0], 3'b000} +: 8] : 8'h00;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      sha1_pkg::S_IDLE: begin
        if (s_acc) begin
          if (fill_q == 6'd63) begin
            state_d = sha1_pkg::S_COMP;
          end else if (s_axis_tlast) begin
            state_d = sha1_pkg::S_PAD;
          end
        end
      end
      sha1_pkg::S_COMP: begin
        if (rnd_q == sha1_pkg::LastRnd) state_d = sha1_pkg::S_FOLD;
      end
      sha1_pkg::S_FOLD: begin
        if (lenblk_q) begin
          state_d = sha1_pkg::S_DONE;
        end else if (pad_q) begin
          state_d = sha1_pkg::S_PAD;
        end else begin
          state_d = sha1_pkg::S_IDLE;
        end
      end
      sha1_pkg::S_PAD: begin
        if (fill_q == 6'd63) state_d = sha1_pkg::S_COMP;
      end
      sha1_pkg::S_DONE: begin
        if (out_free) state_d = sha1_pkg::S_IDLE;
      end
      default: state_d = sha1_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    s_axis_tready = (state_q == sha1_pkg::S_IDLE);
    wr_en         = s_acc || (state_q == sha1_pkg::S_PAD);
    wr_byte       = (state_q == sha1_pkg::S_PAD) ? pad_byte : s_axis_tdata;
    ctl.rnd_en    = (state_q == sha1_pkg::S_COMP);
    ctl.fold      = (state_q == sha1_pkg::S_FOLD);
    ctl.reinit    = (state_q == sha1_pkg::S_DONE) && out_free;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= sha1_pkg::S_IDLE;
      fill_q      <= '0;
      rnd_q       <= '0;
      bitlen_q    <= '0;
      pad_q       <= 1'b0;
      marker_q    <= 1'b0;
      ext_q       <= 1'b0;
      lenblk_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (wr_en) fill_q <= fill_q + 6'd1;
      rnd_q <= ctl.rnd_en ? rnd_q + 7'd1 : '0;
      if (s_acc) begin
        bitlen_q <= bitlen_q + 64'd8;
        if (s_axis_tlast) begin
          pad_q    <= 1'b1;
          marker_q <= 1'b1;
        end
      end
      if (state_q == sha1_pkg::S_PAD) begin
        marker_q <= 1'b0;
        ext_q    <= ext_next;
        if (fill_q == 6'd63) lenblk_q <= !ext_next;
      end
      if (ctl.fold) ext_q <= 1'b0;
      if (ctl.reinit) begin
        bitlen_q    <= '0;
        pad_q       <= 1'b0;
        lenblk_q    <= 1'b0;
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl.reinit) out_data_q <= chain;
  end

  sha1_sched u_sched (
    .clk_i      (clk_i),
    .wr_en_i    (wr_en),
    .wr_idx_i   (fill_q),
    .wr_byte_i  (wr_byte),
    .shift_en_i (ctl.rnd_en),
    .rnd_lt16_i (rnd_q < 7'd16),
    .w_o        (w)
  );

  sha1_core u_core (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (ctl),
    .rnd_i   (rnd_q),
    .w_i     (w),
    .chain_o (chain)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  a_comp_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == sha1_pkg::S_COMP && rnd_q == sha1_pkg::LastRnd)
      |=> state_q == sha1_pkg::S_FOLD)
    else $error("compression did not fold after last round");

  a_comp_aligned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == sha1_pkg::S_COMP |-> fill_q == 6'd0)
    else $error("compression with partial block");

  a_digest_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl.reinit |=> m_axis_tvalid && bitlen_q == 64'd0)
    else $error("digest not presented");

  a_pad_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == sha1_pkg::S_PAD |-> pad_q && !s_axis_tready)
    else $error("padding without final byte");

endmodule

// ===== bench/sha1_byte_stream_hasher_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha1_byte_stream_hasher_tb
// Streams byte messages into the hasher and checks every digest. A directed
// table covers known digests, extreme bytes and one-byte messages. Random
// messages follow, with lengths clustered on the padding boundaries. Both
// handshakes get random gaps. Digests are predicted by a SHA-1 model kept in
// the bench.
// ----------------------------------------------------------------------------
module sha1_byte_stream_hasher_tb;

  localparam int unsigned STALL_LIMIT = 10000;
  localparam int unsigned HOLD_CYCLES = 2000;
  localparam int unsigned TAIL_CYCLES = 300;
  localparam int unsigned ITEM_TARGET = 1900;
  localparam int unsigned MIN_DIGESTS = 40;

  typedef struct {
    logic [7:0]       data;
    logic             fin;
    logic             known;
    sha1_pkg::chain_t dig;
  } stim_row_t;

  logic         clk_i = 1'b0;
  logic         rst_ni;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [7:0]   s_axis_tdata;
  logic         s_axis_tlast;
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [159:0] m_axis_tdata;

  sha1_byte_stream_hasher dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  // hashing state of the bench
  sha1_pkg::chain_t msg_chain;
  logic [7:0]       msg_block [64];
  int unsigned      msg_fill;
  logic [63:0]      msg_bits;

  sha1_pkg::chain_t digest_q [$];
  int unsigned      errors = 0;
  int unsigned      items_sent;
  int unsigned      idle_cycles = 0;
  logic             send_burst;
  logic             recv_burst;

  int unsigned edge_lens [12] = '{1, 2, 55, 56, 57, 63, 64, 65, 119, 120, 127, 128};

  stim_row_t dir_rows [14] = '{
    '{8'h61, 1'b0, 1'b0, '0},
    '{8'h62, 1'b0, 1'b0, '0},
    '{8'h63, 1'b1, 1'b1,
      {32'h9cd0d89d, 32'h7850c26c, 32'hba3e2571, 32'h4706816a, 32'ha9993e36}},
    '{8'h61, 1'b1, 1'b1,
      {32'h377667b8, 32'hb9eaeaea, 32'he15d1ddc, 32'hfaa5a7fc, 32'h86f7e437}},
    '{8'h00, 1'b1, 1'b0, '0},
    '{8'hFF, 1'b1, 1'b0, '0},
    '{8'hFF, 1'b0, 1'b0, '0},
    '{8'h00, 1'b0, 1'b0, '0},
    '{8'h80, 1'b1, 1'b0, '0},
    '{8'h55, 1'b0, 1'b0, '0},
    '{8'hAA, 1'b0, 1'b0, '0},
    '{8'h01, 1'b0, 1'b0, '0},
    '{8'hFE, 1'b0, 1'b0, '0},
    '{8'h7F, 1'b1, 1'b0, '0}
  };

  always #1 clk_i = ~clk_i;

  function automatic void sha1_compress();
    logic [31:0] w [16];
    logic [31:0] a, b, c, d, e, f, t, wr, kc;
    for (int r = 0; r < 16; r++) begin
      w[r] = {msg_block[4*r], msg_block[4*r+1], msg_block[4*r+2], msg_block[4*r+3]};
    end
    a = msg_chain[0];
    b = msg_chain[1];
    c = msg_chain[2];
    d = msg_chain[3];
    e = msg_chain[4];
    for (int r = 0; r < 80; r++) begin
      if (r < 16) begin
        wr = w[r];
      end else begin
        wr = w[(r-3) & 15] ^ w[(r-8) & 15] ^ w[(r-14) & 15] ^ w[r & 15];
        wr = {wr[30:0], wr[31]};
        w[r & 15] = wr;
      end
      if (r < 20) begin
        f  = (b & c) | (~b & d);
        kc = sha1_pkg::K0;
      end else if (r < 40) begin
        f  = b ^ c ^ d;
        kc = sha1_pkg::K1;
      end else if (r < 60) begin
        f  = (b & c) | (b & d) | (c & d);
        kc = sha1_pkg::K2;
      end else begin
        f  = b ^ c ^ d;
        kc = sha1_pkg::K3;
      end
      t = {a[26:0], a[31:27]} + f + e + kc + wr;
      e = d;
      d = c;
      c = {b[1:0], b[31:2]};
      b = a;
      a = t;
    end
    msg_chain[0] += a;
    msg_chain[1] += b;
    msg_chain[2] += c;
    msg_chain[3] += d;
    msg_chain[4] += e;
  endfunction

  function automatic void hash_restart();
    msg_chain = {sha1_pkg::H4, sha1_pkg::H3, sha1_pkg::H2, sha1_pkg::H1, sha1_pkg::H0};
    msg_fill  = 0;
    msg_bits  = '0;
  endfunction

  // absorb one byte; on the final byte pad, finish and return the digest
  function automatic logic hash_byte(input logic [7:0] data, input logic fin,
                                     output sha1_pkg::chain_t dig);
    int unsigned pos;
    msg_block[msg_fill] = data;
    msg_fill++;
    msg_bits += 64'd8;
    if (msg_fill == 64) begin
      sha1_compress();
      msg_fill = 0;
    end
    if (!fin) begin
      return 1'b0;
    end
    pos = msg_fill;
    msg_block[pos] = sha1_pkg::PadMarker;
    pos++;
    if (pos > 56) begin
      while (pos < 64) begin
        msg_block[pos] = 8'h00;
        pos++;
      end
      sha1_compress();
      pos = 0;
    end
    while (pos < 56) begin
      msg_block[pos] = 8'h00;
      pos++;
    end
    for (int k = 0; k < 8; k++) begin
      msg_block[56+k] = msg_bits[63-8*k -: 8];
    end
    sha1_compress();
    dig = msg_chain;
    hash_restart();
    return 1'b1;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] exp_v,
                                 input logic [31:0] got_v);
    $display("%0t mismatch %s: expected %08h, got %08h", $realtime, what, exp_v, got_v);
    errors++;
  endtask

  task automatic send_byte(input logic [7:0] data, input logic fin, input logic known,
                           input sha1_pkg::chain_t known_dig);
    int unsigned      gap;
    sha1_pkg::chain_t dig;
    gap = send_burst ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= data;
    s_axis_tlast  <= fin;
    do @(posedge clk_i); while (!(s_axis_tvalid && s_axis_tready));
    items_sent++;
    if (hash_byte(data, fin, dig)) begin
      digest_q.push_back(known ? known_dig : dig);
    end
  endtask

  task automatic send_message(input int unsigned len);
    int unsigned fill_kind;
    logic [7:0]  data;
    fill_kind = $urandom_range(0, 7);
    for (int unsigned i = 0; i < len; i++) begin
      case (fill_kind)
        0: data = 8'h00;
        1: data = 8'hFF;
        default: data = 8'($urandom_range(0, 255));
      endcase
      send_byte(data, i == len - 1, 1'b0, '0);
    end
  endtask

  // digest check
  always @(posedge clk_i) begin
    if (m_axis_tvalid && m_axis_tready) begin
      if (digest_q.size() == 0) begin
        report_mismatch("unexpected digest, digest_word0", 32'h0, m_axis_tdata[31:0]);
      end else begin
        sha1_pkg::chain_t exp_dig;
        sha1_pkg::chain_t got_dig;
        exp_dig = digest_q.pop_front();
        got_dig = m_axis_tdata;
        for (int k = 0; k < 5; k++) begin
          if (got_dig[k] !== exp_dig[k]) begin
            report_mismatch($sformatf("digest_word%0d", k), exp_dig[k], got_dig[k]);
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles + 1 >= STALL_LIMIT) begin
        $display("sha1_byte_stream_hasher_tb: FAIL");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // result side
  initial begin
    int unsigned wait_cycles;
    int unsigned taken;
    taken = 0;
    recv_burst = 1'b0;
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (taken % 16 == 0) begin
        recv_burst = ($urandom_range(0, 3) == 0);
      end
      if (taken == 8) begin
        wait_cycles = HOLD_CYCLES;
      end else begin
        wait_cycles = recv_burst ? 0 : $urandom_range(0, 9);
      end
      if (wait_cycles > 0) begin
        m_axis_tready <= 1'b0;
        repeat (wait_cycles) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!(m_axis_tvalid && m_axis_tready));
      taken++;
    end
  end

  initial begin
    int unsigned msg_count;
    int unsigned len;
    int unsigned pick;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tlast  = 1'b0;
    items_sent    = 0;
    send_burst    = 1'b0;
    msg_count     = 0;
    for (int k = 0; k < 64; k++) begin
      msg_block[k] = 8'h00;
    end
    hash_restart();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i]) begin
      send_byte(dir_rows[i].data, dir_rows[i].fin, dir_rows[i].known, dir_rows[i].dig);
    end

    // drain before random traffic
    s_axis_tvalid <= 1'b0;
    wait (digest_q.size() == 0);
    @(posedge clk_i);

    while (items_sent < ITEM_TARGET || msg_count < MIN_DIGESTS) begin
      send_burst = ($urandom_range(0, 3) == 0);
      pick = $urandom_range(0, 9);
      if (pick < 4) begin
        len = edge_lens[$urandom_range(0, 11)];
      end else if (pick < 8) begin
        len = $urandom_range(1, 20);
      end else begin
        len = $urandom_range(1, 140);
      end
      send_message(len);
      msg_count++;
      if (msg_count == 25) begin
        s_axis_tvalid <= 1'b0;
        wait (digest_q.size() == 0);
        @(posedge clk_i);
      end
    end
    s_axis_tvalid <= 1'b0;

    wait (digest_q.size() == 0);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (errors == 0) begin
      $display("sha1_byte_stream_hasher_tb: PASS");
    end else begin
      $display("sha1_byte_stream_hasher_tb: FAIL");
    end
    $finish;
  end

endmodule
